// ----- design/glzw_pkg.sv -----
// Package for the GIF LZW pixel decoder: word types, operation and status codes,
// controller states and fixed constants. No dependencies.
`default_nettype none

package glzw_pkg;

  localparam int BUF_BITS   = 20;  // bit buffer width
  localparam int PUSH_LIMIT = 12;  // a data byte is refused above this many buffered bits
  localparam int MIN_LO     = 2;
  localparam int MIN_HI     = 8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PUSH  = 2'd1,
    OP_PULL  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NEED    = 3'd1,
    ST_REFUSED = 3'd2,
    ST_END     = 3'd3,
    ST_ERROR   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_CODE,
    S_READ
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] pixel_index;
  } out_word_t;

endpackage

`default_nettype wire

// ----- design/glzw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/gif_lzw_pixel_decoder.sv -----
// GIF variable-width LZW pixel decoder, top level.
// Depends on glzw_pkg and glzw_ram.
//
// Usage
//   Input channel (in_valid/in_ready/in_data) takes one word per item:
//   start, push a raw stream byte (sub-block length bytes included and
//   stripped here) or pull the next pixel. Every item yields exactly one
//   result word on the output channel (out_valid/out_ready/out_data).
//   cfg_we/cfg_wdata write the minimum code size; write only while idle.
// Sequencing
//   Start, push and the unused operation: result in the cycle after accept.
//   Pull with pixels stacked: through S_POP (one stack RAM read).
//   Pull that decodes a code: S_CODE for each code consumed (clear codes
//   loop here), then S_READ for each table entry walked, as every step of
//   the chain is a read of the prefix/suffix RAM with registered read data.
//   Each walked entry above the root stacks one pixel.
// Throughput
//   One item in flight; a new word is taken once the controller is idle and
//   the output register is empty or being emptied in the same cycle.
// Reset
//   Synchronous, active low. Control registers return to their defaults;
//   the RAMs are not cleared. The table is tracked by the clear code and
//   next free code in force since the last restart, so no clearing pass.
// Stall
//   A stalled receiver holds the result register, and no new word is taken.
`default_nettype none

module gif_lzw_pixel_decoder #(
  parameter int CODE_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire glzw_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output glzw_pkg::out_word_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [3:0]           cfg_wdata
);

  import glzw_pkg::*;

  localparam int TBL = 1 << CODE_BITS;
  localparam int NW  = CODE_BITS + 1;   // holds TBL itself
  localparam int EW  = CODE_BITS + 8;   // prefix and suffix per entry

  // control and table bookkeeping
  state_t              state_r, state_nxt;
  logic [3:0]          min_r, min_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;       // stack fill
  logic [3:0]          cw_r, cw_nxt;         // code width
  logic [NW-1:0]       nfc_r, nfc_nxt;       // next free code
  logic [NW-1:0]       lim_r, lim_nxt;       // width limit
  logic [NW-1:0]       cr_r, cr_nxt;         // clear code at last restart
  logic [7:0]          fs_r, fs_nxt;         // first symbol
  logic [CODE_BITS-1:0] prev_r, prev_nxt;
  logic [CODE_BITS-1:0] inc_r, inc_nxt;      // incoming code
  logic [CODE_BITS-1:0] cur_r, cur_nxt;      // chain walk position
  logic [BUF_BITS-1:0] buf_r, buf_nxt;
  logic [4:0]          bc_r, bc_nxt;
  logic [7:0]          bbl_r, bbl_nxt;
  logic                fresh_r, fresh_nxt;
  logic                done_r, done_nxt;
  logic                ended_r, ended_nxt;
  logic                ov_r, ov_nxt;
  out_word_t           out_r, out_nxt;

  // RAM ports
  logic                 tb_we, sk_we;
  logic [CODE_BITS-1:0] tb_waddr, tb_raddr, sk_waddr, sk_raddr;
  logic [EW-1:0]        tb_wdata, tb_rdata;
  logic [7:0]           sk_wdata, sk_rdata;

  // derived
  logic [3:0]           m_eff;
  logic [NW-1:0]        clr;
  logic [BUF_BITS-1:0]  cmask;
  logic [CODE_BITS-1:0] code;
  logic [NW-1:0]        codew;
  logic                 written, literal;
  logic [CODE_BITS-1:0] e_pre;
  logic [7:0]           e_suf;
  logic [NW-1:0]        nfc_inc;

  glzw_ram #(.WIDTH(EW), .DEPTH(TBL)) u_table (
    .clk, .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(TBL)) u_stack (
    .clk, .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(sk_raddr), .rdata(sk_rdata)
  );

  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    m_eff = (min_r < 4'(MIN_LO)) ? 4'(MIN_LO) : (min_r > 4'(MIN_HI)) ? 4'(MIN_HI) : min_r;
    clr   = NW'(1) << m_eff;
    cmask = (BUF_BITS'(1) << cw_r) - BUF_BITS'(1);
    code  = CODE_BITS'(buf_r & cmask);
    codew = NW'(code);
    // entries read back as restart values unless written since restart
    written = (NW'(cur_r) >= cr_r + NW'(2)) && (NW'(cur_r) < nfc_r);
    literal = NW'(cur_r) < cr_r;
    e_pre   = written ? tb_rdata[EW-1:8] : '0;
    e_suf   = written ? tb_rdata[7:0] : (literal ? cur_r[7:0] : 8'd0);
    nfc_inc = nfc_r + NW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    min_nxt   = cfg_we ? cfg_wdata : min_r;
    cnt_nxt   = cnt_r;
    cw_nxt    = cw_r;
    nfc_nxt   = nfc_r;
    lim_nxt   = lim_r;
    cr_nxt    = cr_r;
    fs_nxt    = fs_r;
    prev_nxt  = prev_r;
    inc_nxt   = inc_r;
    cur_nxt   = cur_r;
    buf_nxt   = buf_r;
    bc_nxt    = bc_r;
    bbl_nxt   = bbl_r;
    fresh_nxt = fresh_r;
    done_nxt  = done_r;
    ended_nxt = ended_r;
    ov_nxt    = ov_r && !out_ready;
    out_nxt   = out_r;
    tb_we     = 1'b0;
    tb_waddr  = nfc_r[CODE_BITS-1:0];
    tb_wdata  = {prev_r, e_suf};
    tb_raddr  = cur_r;
    sk_we     = 1'b0;
    sk_waddr  = cnt_r[CODE_BITS-1:0];
    sk_wdata  = e_suf;
    sk_raddr  = CODE_BITS'(cnt_r - NW'(1));

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ov_nxt  = 1'b1;
          out_nxt = '{status: ST_OK, pixel_index: 8'd0};
          case (op_t'(in_data.operation))
            OP_START: begin
              buf_nxt   = '0;
              bc_nxt    = '0;
              bbl_nxt   = '0;
              done_nxt  = 1'b0;
              ended_nxt = 1'b0;
              fresh_nxt = 1'b1;
              cr_nxt    = clr;
              cw_nxt    = m_eff + 4'd1;
              nfc_nxt   = clr + NW'(2);
              lim_nxt   = clr << 1;
              cnt_nxt   = '0;
            end
            OP_PUSH: begin
              if (ended_r || done_r) begin
                out_nxt.status = ST_REFUSED;
              end else if (bbl_r == 8'd0) begin
                if (in_data.data_byte == 8'd0) begin
                  done_nxt = 1'b1;
                end else begin
                  bbl_nxt = in_data.data_byte;
                end
              end else if (bc_r > 5'(PUSH_LIMIT)) begin
                out_nxt.status = ST_REFUSED;
              end else begin
                buf_nxt = buf_r | (BUF_BITS'(in_data.data_byte) << bc_r);
                bc_nxt  = bc_r + 5'd8;
                bbl_nxt = bbl_r - 8'd1;
              end
            end
            OP_PULL: begin
              if (ended_r) begin
                out_nxt.status = ST_END;
              end else if (cnt_r != '0) begin
                ov_nxt    = 1'b0;
                cnt_nxt   = cnt_r - NW'(1);
                state_nxt = S_POP;
              end else begin
                ov_nxt    = 1'b0;
                state_nxt = S_CODE;
              end
            end
            default: ;
          endcase
        end
      end

      S_POP: begin
        ov_nxt    = 1'b1;
        out_nxt   = '{status: ST_OK, pixel_index: sk_rdata};
        state_nxt = S_IDLE;
      end

      S_CODE: begin
        if (bc_r < 5'(cw_r)) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if (done_r) begin
            ended_nxt = 1'b1;
            out_nxt   = '{status: ST_END, pixel_index: 8'd0};
          end else begin
            out_nxt   = '{status: ST_NEED, pixel_index: 8'd0};
          end
        end else begin
          buf_nxt = buf_r >> cw_r;
          bc_nxt  = bc_r - 5'(cw_r);
          if (codew == clr) begin
            // clear code: restart the table and keep decoding
            fresh_nxt = 1'b1;
            cr_nxt    = clr;
            cw_nxt    = m_eff + 4'd1;
            nfc_nxt   = clr + NW'(2);
            lim_nxt   = clr << 1;
            cnt_nxt   = '0;
          end else if (codew == clr + NW'(1)) begin
            ended_nxt = 1'b1;
            ov_nxt    = 1'b1;
            out_nxt   = '{status: ST_END, pixel_index: 8'd0};
            state_nxt = S_IDLE;
          end else if (fresh_r) begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
            if (codew >= clr) begin
              ended_nxt = 1'b1;
              cnt_nxt   = '0;
              out_nxt   = '{status: ST_ERROR, pixel_index: 8'd0};
            end else begin
              fs_nxt    = code[7:0];
              prev_nxt  = code;
              fresh_nxt = 1'b0;
              out_nxt   = '{status: ST_OK, pixel_index: code[7:0]};
            end
          end else if (codew > nfc_r) begin
            ended_nxt = 1'b1;
            cnt_nxt   = '0;
            ov_nxt    = 1'b1;
            out_nxt   = '{status: ST_ERROR, pixel_index: 8'd0};
            state_nxt = S_IDLE;
          end else begin
            inc_nxt = code;
            if (codew == nfc_r) begin
              // KwKwK: the first symbol goes to the bottom of the stack
              sk_we    = 1'b1;
              sk_waddr = cnt_r[CODE_BITS-1:0];
              sk_wdata = fs_r;
              cnt_nxt  = cnt_r + NW'(1);
              cur_nxt  = prev_r;
            end else begin
              cur_nxt  = code;
            end
            tb_raddr  = cur_nxt;
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        if (NW'(cur_r) >= clr) begin
          if (cnt_r >= NW'(TBL) || e_pre == cur_r) begin
            ended_nxt = 1'b1;
            cnt_nxt   = '0;
            ov_nxt    = 1'b1;
            out_nxt   = '{status: ST_ERROR, pixel_index: 8'd0};
            state_nxt = S_IDLE;
          end else begin
            sk_we    = 1'b1;
            cnt_nxt  = cnt_r + NW'(1);
            cur_nxt  = e_pre;
            tb_raddr = e_pre;
          end
        end else if (cnt_r >= NW'(TBL)) begin
          ended_nxt = 1'b1;
          cnt_nxt   = '0;
          ov_nxt    = 1'b1;
          out_nxt   = '{status: ST_ERROR, pixel_index: 8'd0};
          state_nxt = S_IDLE;
        end else begin
          // root reached: its symbol is output at once without being stacked
          fs_nxt = e_suf;
          if (nfc_r < NW'(TBL)) begin
            tb_we   = 1'b1;
            nfc_nxt = nfc_inc;
            if (nfc_inc >= lim_r && lim_r < NW'(TBL)) begin
              lim_nxt = lim_r << 1;
              cw_nxt  = cw_r + 4'd1;
            end
          end
          prev_nxt  = inc_r;
          ov_nxt    = 1'b1;
          out_nxt   = '{status: ST_OK, pixel_index: e_suf};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      min_r   <= 4'd8;
      cnt_r   <= '0;
      cw_r    <= 4'd9;
      nfc_r   <= NW'(258);
      lim_r   <= NW'(512);
      cr_r    <= NW'(256);
      fs_r    <= '0;
      prev_r  <= '0;
      buf_r   <= '0;
      bc_r    <= '0;
      bbl_r   <= '0;
      fresh_r <= 1'b0;
      done_r  <= 1'b0;
      ended_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      min_r   <= min_nxt;
      cnt_r   <= cnt_nxt;
      cw_r    <= cw_nxt;
      nfc_r   <= nfc_nxt;
      lim_r   <= lim_nxt;
      cr_r    <= cr_nxt;
      fs_r    <= fs_nxt;
      prev_r  <= prev_nxt;
      buf_r   <= buf_nxt;
      bc_r    <= bc_nxt;
      bbl_r   <= bbl_nxt;
      fresh_r <= fresh_nxt;
      done_r  <= done_nxt;
      ended_r <= ended_nxt;
      ov_r    <= ov_nxt;
    end
    inc_r <= inc_nxt;
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ----- design/glzw_checker.sv -----
// Port-level checker for the GIF LZW pixel decoder, bound to the top level.
// Depends on glzw_pkg.
`default_nettype none

module glzw_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire glzw_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire glzw_pkg::out_word_t out_data
);

  import glzw_pkg::*;

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a word is only taken when the result register can drain
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("word accepted over a stalled result");

  // everything but a pull answers in the next cycle
  a_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation != OP_PULL |=> out_valid)
    else $error("non-pull word gave no result next cycle");

  // pixel index is zero unless the status is ok
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.pixel_index == 8'd0)
    else $error("pixel index set on a non-ok status");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gif_lzw_pixel_decoder glzw_checker u_glzw_checker (.*);

`default_nettype wire
